[rtl/cfpa_pkg.sv]
package cfpa_pkg;

    localparam int CFPA_FRAC_BITS = 16;
    localparam int CFPA_QB        = 33;

    typedef enum logic [2:0] {
        CMD_ADD     = 3'd0,
        CMD_SUB     = 3'd1,
        CMD_MUL     = 3'd2,
        CMD_DIV     = 3'd3,
        CMD_LESS    = 3'd4,
        CMD_GREATER = 3'd5,
        CMD_EQUAL   = 3'd6,
        CMD_CONJ    = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } t_status;

    typedef struct packed {
        logic        sat;
        logic [31:0] val;
    } t_sat;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] res_re;
        logic [31:0] res_im;
        logic        cmp;
        t_status     status;
        logic        neg_re;
        logic        neg_im;
        logic        ovf_re;
        logic        ovf_im;
        logic        dz;
    } t_side;

    function automatic t_sat f_sat33(input logic signed [32:0] v);
        t_sat r;
        r.sat = 1'b0;
        r.val = v[31:0];
        if (v > 33'sh0_7FFF_FFFF) begin
            r.sat = 1'b1;
            r.val = 32'h7FFF_FFFF;
        end else if (v < 33'sh1_8000_0000) begin
            r.sat = 1'b1;
            r.val = 32'h8000_0000;
        end
        return r;
    endfunction

    function automatic t_sat f_sat65(input logic signed [64:0] v);
        t_sat r;
        r.sat = 1'b0;
        r.val = v[31:0];
        if (v > 65'sh0_0000_0000_7FFF_FFFF) begin
            r.sat = 1'b1;
            r.val = 32'h7FFF_FFFF;
        end else if (v < 65'sh1_FFFF_FFFF_8000_0000) begin
            r.sat = 1'b1;
            r.val = 32'h8000_0000;
        end
        return r;
    endfunction

    // quotient magnitude with sign back to a saturated part
    function automatic t_sat f_div_sat(input logic neg, input logic ovf,
                                       input logic [CFPA_QB-1:0] q);
        t_sat r;
        r.sat = 1'b0;
        r.val = 32'h0;
        if (!neg) begin
            if (ovf || q > CFPA_QB'(33'h0_7FFF_FFFF)) begin
                r.sat = 1'b1;
                r.val = 32'h7FFF_FFFF;
            end else begin
                r.val = q[31:0];
            end
        end else begin
            if (ovf || q > CFPA_QB'(33'h0_8000_0000)) begin
                r.sat = 1'b1;
                r.val = 32'h8000_0000;
            end else begin
                r.val = 32'h0 - q[31:0];
            end
        end
        return r;
    endfunction

endpackage

[rtl/complex_fixed_point_alu.sv]
// Complex fixed-point ALU on signed Q16.16 operands (fraction width set by FRAC_BITS).
// A new request can be taken every cycle while the output side does not stall. The
// pipeline has one restoring-division step per stage for each of the 33 quotient bits,
// behind a multiply stage, a sum stage and a scaling stage, plus the output register.
// Every stage has its own valid bit and moves up when the stage after it is free,
// so bubbles close up under output back-pressure. Division by zero returns zero
// with status 2; out-of-range parts saturate with status 1.
module complex_fixed_point_alu import cfpa_pkg::*; #(
    parameter int FRAC_BITS = CFPA_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_cmd,
    input  logic signed [31:0] i_a_re,
    input  logic signed [31:0] i_a_im,
    input  logic signed [31:0] i_b_re,
    input  logic signed [31:0] i_b_im,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_res_re,
    output logic signed [31:0] o_res_im,
    output logic               o_cmp_true,
    output logic [1:0]         o_status
);

    localparam int QB   = CFPA_QB;
    localparam int MAGW = 64;
    localparam int WR   = (MAGW + FRAC_BITS > MAGW + QB - 1) ? MAGW + FRAC_BITS
                                                             : MAGW + QB - 1;
    localparam int NS   = QB + 4;
    localparam int LAST = NS - 1;

    logic [NS-1:0] r_v;
    logic [NS:0]   adv;

    always_comb begin
        adv[NS] = i_out_ready;
        for (int i = NS - 1; i >= 0; i--) begin
            adv[i] = !r_v[i] || adv[i+1];
        end
    end

    assign o_in_ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (adv[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // stage 1: products and the simple operations
    t_side              n1_side;
    t_sat               n1_s_re, n1_s_im;
    t_side              r1_side;
    logic signed [63:0] r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir;
    logic signed [63:0] r1_p_aar, r1_p_aai, r1_p_bbr, r1_p_bbi;

    always_comb begin
        n1_side        = '0;
        n1_side.cmd    = t_cmd'(i_cmd);
        n1_side.status = ST_OK;
        n1_s_re        = f_sat33(33'(i_a_re) + 33'(i_b_re));
        n1_s_im        = f_sat33(33'(i_a_im) + 33'(i_b_im));
        case (t_cmd'(i_cmd))
            CMD_SUB: begin
                n1_s_re = f_sat33(33'(i_a_re) - 33'(i_b_re));
                n1_s_im = f_sat33(33'(i_a_im) - 33'(i_b_im));
            end
            CMD_CONJ: begin
                n1_s_re = f_sat33(33'(i_a_re));
                n1_s_im = f_sat33(33'sd0 - 33'(i_a_im));
            end
            default: begin
            end
        endcase
        case (t_cmd'(i_cmd))
            CMD_ADD, CMD_SUB, CMD_CONJ: begin
                n1_side.res_re = n1_s_re.val;
                n1_side.res_im = n1_s_im.val;
                n1_side.status = (n1_s_re.sat || n1_s_im.sat) ? ST_SAT : ST_OK;
            end
            CMD_EQUAL: begin
                n1_side.cmp = (i_a_re == i_b_re) && (i_a_im == i_b_im);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_side  <= n1_side;
            r1_p_rr  <= i_a_re * i_b_re;
            r1_p_ii  <= i_a_im * i_b_im;
            r1_p_ri  <= i_a_re * i_b_im;
            r1_p_ir  <= i_a_im * i_b_re;
            r1_p_aar <= i_a_re * i_a_re;
            r1_p_aai <= i_a_im * i_a_im;
            r1_p_bbr <= i_b_re * i_b_re;
            r1_p_bbi <= i_b_im * i_b_im;
        end
    end

    // stage 2: sums of products
    t_side              r2_side;
    logic signed [64:0] r2_s_re, r2_s_im;
    logic [MAGW-1:0]    r2_ma, r2_mb;
    logic               n2_is_mul;

    assign n2_is_mul = (r1_side.cmd == CMD_MUL);

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r2_side <= r1_side;
            r2_s_re <= n2_is_mul ? 65'(r1_p_rr) - 65'(r1_p_ii) : 65'(r1_p_rr) + 65'(r1_p_ii);
            r2_s_im <= n2_is_mul ? 65'(r1_p_ri) + 65'(r1_p_ir) : 65'(r1_p_ir) - 65'(r1_p_ri);
            r2_ma   <= $unsigned(r1_p_aar) + $unsigned(r1_p_aai);
            r2_mb   <= $unsigned(r1_p_bbr) + $unsigned(r1_p_bbi);
        end
    end

    // stage 3: scaling, compares, divider set-up
    t_side              n3_side;
    logic signed [64:0] n3_sh_re, n3_sh_im;
    t_sat               n3_m_re, n3_m_im;
    logic [64:0]        n3_abs_re, n3_abs_im;
    logic [MAGW-1:0]    n3_mag_re, n3_mag_im;

    t_side           r_side   [0:QB];
    logic [WR-1:0]   r_rem_re [0:QB];
    logic [WR-1:0]   r_rem_im [0:QB];
    logic [MAGW-1:0] r_den    [0:QB];
    logic [QB-1:0]   r_q_re   [1:QB];
    logic [QB-1:0]   r_q_im   [1:QB];

    always_comb begin
        n3_side   = r2_side;
        n3_sh_re  = r2_s_re >>> FRAC_BITS;
        n3_sh_im  = r2_s_im >>> FRAC_BITS;
        n3_m_re   = f_sat65(n3_sh_re);
        n3_m_im   = f_sat65(n3_sh_im);
        n3_abs_re = r2_s_re[64] ? 65'sd0 - r2_s_re : r2_s_re;
        n3_abs_im = r2_s_im[64] ? 65'sd0 - r2_s_im : r2_s_im;
        n3_mag_re = n3_abs_re[MAGW-1:0];
        n3_mag_im = n3_abs_im[MAGW-1:0];
        case (r2_side.cmd)
            CMD_MUL: begin
                n3_side.res_re = n3_m_re.val;
                n3_side.res_im = n3_m_im.val;
                n3_side.status = (n3_m_re.sat || n3_m_im.sat) ? ST_SAT : ST_OK;
            end
            CMD_DIV: begin
                n3_side.neg_re = r2_s_re[64];
                n3_side.neg_im = r2_s_im[64];
                n3_side.ovf_re = (n3_mag_re >> (QB - FRAC_BITS)) >= r2_mb;
                n3_side.ovf_im = (n3_mag_im >> (QB - FRAC_BITS)) >= r2_mb;
                n3_side.dz     = (r2_mb == '0);
            end
            CMD_LESS: begin
                n3_side.cmp = (r2_ma < r2_mb);
            end
            CMD_GREATER: begin
                n3_side.cmp = (r2_ma > r2_mb);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_side[0]   <= n3_side;
            r_rem_re[0] <= WR'(n3_mag_re) << FRAC_BITS;
            r_rem_im[0] <= WR'(n3_mag_im) << FRAC_BITS;
            r_den[0]    <= r2_mb;
        end
    end

    // restoring division, one quotient bit per stage, most significant first
    for (genvar d = 1; d <= QB; d++) begin : g_div
        localparam int K = QB - d;
        logic [WR-1:0] n_dsh;
        logic          n_ge_re, n_ge_im;

        assign n_dsh   = WR'(r_den[d-1]) << K;
        assign n_ge_re = (r_rem_re[d-1] >= n_dsh);
        assign n_ge_im = (r_rem_im[d-1] >= n_dsh);

        always_ff @(posedge i_clk) begin
            if (adv[d+2]) begin
                r_side[d]   <= r_side[d-1];
                r_den[d]    <= r_den[d-1];
                r_rem_re[d] <= n_ge_re ? r_rem_re[d-1] - n_dsh : r_rem_re[d-1];
                r_rem_im[d] <= n_ge_im ? r_rem_im[d-1] - n_dsh : r_rem_im[d-1];
            end
        end

        if (d == 1) begin : g_first
            always_ff @(posedge i_clk) begin
                if (adv[d+2]) begin
                    r_q_re[d] <= QB'(n_ge_re);
                    r_q_im[d] <= QB'(n_ge_im);
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (adv[d+2]) begin
                    r_q_re[d] <= {r_q_re[d-1][QB-2:0], n_ge_re};
                    r_q_im[d] <= {r_q_im[d-1][QB-2:0], n_ge_im};
                end
            end
        end
    end

    // output stage
    t_side              n_out;
    t_sat               n_d_re, n_d_im;
    logic signed [31:0] r_out_re, r_out_im;
    logic               r_out_cmp;
    t_status            r_out_st;

    always_comb begin
        n_out  = r_side[QB];
        n_d_re = f_div_sat(r_side[QB].neg_re, r_side[QB].ovf_re, r_q_re[QB]);
        n_d_im = f_div_sat(r_side[QB].neg_im, r_side[QB].ovf_im, r_q_im[QB]);
        if (r_side[QB].cmd == CMD_DIV) begin
            if (r_side[QB].dz) begin
                n_out.res_re = '0;
                n_out.res_im = '0;
                n_out.cmp    = 1'b0;
                n_out.status = ST_DIVZ;
            end else begin
                n_out.res_re = n_d_re.val;
                n_out.res_im = n_d_im.val;
                n_out.status = (n_d_re.sat || n_d_im.sat) ? ST_SAT : ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[LAST]) begin
            r_out_re  <= n_out.res_re;
            r_out_im  <= n_out.res_im;
            r_out_cmp <= n_out.cmp;
            r_out_st  <= n_out.status;
        end
    end

    assign o_out_valid = r_v[LAST];
    assign o_res_re    = r_out_re;
    assign o_res_im    = r_out_im;
    assign o_cmp_true  = r_out_cmp;
    assign o_status    = r_out_st;

    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_DIVZ) |->
            (o_res_re == '0 && o_res_im == '0 && !o_cmp_true))
        else $error("divide by zero result not cleared");

    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_cmp_true) |->
            (o_res_re == '0 && o_res_im == '0 && o_status == ST_OK))
        else $error("compare result carries data");

    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_SAT) |->
            (o_res_re == 32'sh7FFF_FFFF || o_res_re == 32'sh8000_0000 ||
             o_res_im == 32'sh7FFF_FFFF || o_res_im == 32'sh8000_0000))
        else $error("saturated status without a part at a rail");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[LAST] && !i_out_ready) |=> (r_v[LAST] && $stable(r_out_re)))
        else $error("stalled result lost");

endmodule

[dv/cfpa_checker.sv]
module cfpa_checker import cfpa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [2:0]         i_cmd,
    input  logic signed [31:0] i_a_re,
    input  logic signed [31:0] i_a_im,
    input  logic signed [31:0] i_b_re,
    input  logic signed [31:0] i_b_im,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_res_re,
    input  logic signed [31:0] i_res_im,
    input  logic               i_cmp_true,
    input  logic [1:0]         i_status,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        cmp;
        t_status     status;
    } t_alu_res;

    t_alu_res results_q[$];

    function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic sat);
        if (v > 128'sd2147483647) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -128'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [127:0] div_trunc(input logic signed [127:0] num,
                                                      input logic signed [127:0] den);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (num < 0) ? -num : num;
        q   = (mag << CFPA_FRAC_BITS) / den;
        return (num < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic t_alu_res alu_predict(input t_cmd cmd,
                                             input logic signed [31:0] a_re, a_im, b_re, b_im);
        t_alu_res r;
        logic signed [127:0] ar, ai, br, bi, x, y, den, ma, mb;
        logic sat;
        ar = a_re;
        ai = a_im;
        br = b_re;
        bi = b_im;
        r = '0;
        r.status = ST_OK;
        sat = 1'b0;
        case (cmd)
            CMD_ADD, CMD_SUB: begin
                x = (cmd == CMD_SUB) ? ar - br : ar + br;
                y = (cmd == CMD_SUB) ? ai - bi : ai + bi;
                r.re = clamp32(x, sat);
                r.im = clamp32(y, sat);
            end
            CMD_MUL: begin
                x = (ar * br - ai * bi) >>> CFPA_FRAC_BITS;
                y = (ar * bi + ai * br) >>> CFPA_FRAC_BITS;
                r.re = clamp32(x, sat);
                r.im = clamp32(y, sat);
            end
            CMD_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.status = ST_DIVZ;
                end else begin
                    r.re = clamp32(div_trunc(ar * br + ai * bi, den), sat);
                    r.im = clamp32(div_trunc(ai * br - ar * bi, den), sat);
                end
            end
            CMD_LESS, CMD_GREATER: begin
                ma = ar * ar + ai * ai;
                mb = br * br + bi * bi;
                r.cmp = (cmd == CMD_LESS) ? (ma < mb) : (ma > mb);
            end
            CMD_EQUAL: r.cmp = (ar == br) && (ai == bi);
            default: begin
                r.re = clamp32(ar, sat);
                r.im = clamp32(-ai, sat);
            end
        endcase
        if (sat) r.status = ST_SAT;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("checker: mismatch at %0t: %s", $time, what);
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_pending = results_q.size();

    always @(posedge i_clk) begin
        t_alu_res e;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                results_q.push_back(alu_predict(t_cmd'(i_cmd), i_a_re, i_a_im, i_b_re, i_b_im));
            if (i_out_valid && i_out_ready) begin
                if (results_q.size() == 0) begin
                    report_mismatch("result with no request pending");
                end else begin
                    e = results_q.pop_front();
                    if (i_res_re !== e.re)
                        report_mismatch($sformatf("res_re %h exp %h", i_res_re, e.re));
                    if (i_res_im !== e.im)
                        report_mismatch($sformatf("res_im %h exp %h", i_res_im, e.im));
                    if (i_cmp_true !== e.cmp)
                        report_mismatch($sformatf("cmp_true %b exp %b", i_cmp_true, e.cmp));
                    if (i_status !== e.status)
                        report_mismatch($sformatf("status %0d exp %0d", i_status, e.status));
                end
            end
        end
    end
endmodule

[dv/tb.sv]
module tb import cfpa_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [2:0]         i_cmd;
    logic signed [31:0] i_a_re, i_a_im, i_b_re, i_b_im;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_res_re, o_res_im;
    logic               o_cmp_true;
    logic [1:0]         o_status;
    int                 errors, pending;

    complex_fixed_point_alu uut (.*);

    cfpa_checker chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_cmd,
        .i_a_re, .i_a_im, .i_b_re, .i_b_im, .i_out_valid(o_out_valid),
        .i_out_ready, .i_res_re(o_res_re), .i_res_im(o_res_im),
        .i_cmp_true(o_cmp_true), .i_status(o_status),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("tb: done, errors");
        $finish;
    end

    // receiver back-pressure, own pattern
    initial begin
        int mode, len;
        i_out_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(1, 40);
            repeat (len) begin
                @(negedge i_clk);
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 3) != 0);
                    2: i_out_ready <= ($urandom_range(0, 1) != 0);
                    default: i_out_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    int burst_left;

    task automatic send_request(input t_cmd cmd, input logic [31:0] ar, ai, br, bi);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_a_re     <= ar;
        i_a_im     <= ai;
        i_b_re     <= br;
        i_b_im     <= bi;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_part();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 3) << 16;
            3: return $signed($urandom_range(0, 2 ** 20)) - 32'sd524288;
            default: return $urandom;
        endcase
    endfunction

    localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
    localparam logic [31:0] MINN = 32'h8000_0000;
    localparam logic [31:0] ONE  = 32'h0001_0000;

    initial begin
        logic [31:0] ar, ai, br, bi;
        t_cmd c;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_cmd      = CMD_ADD;
        i_a_re     = '0;
        i_a_im     = '0;
        i_b_re     = '0;
        i_b_im     = '0;
        burst_left = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(CMD_ADD, MAXP, MINN, MAXP, MINN);
        send_request(CMD_ADD, ONE, -ONE, 32'h3, 32'h5);
        send_request(CMD_SUB, MAXP, MINN, MINN, MAXP);
        send_request(CMD_SUB, MINN, 0, MINN, 0);
        send_request(CMD_MUL, MAXP, MAXP, MAXP, MINN);
        send_request(CMD_MUL, MINN, MINN, MINN, MINN);
        send_request(CMD_MUL, 32'hFFFF_FFFF, 0, 32'h1, 0);
        send_request(CMD_MUL, ONE, ONE, ONE, -ONE);
        send_request(CMD_DIV, ONE, ONE, 0, 0);
        send_request(CMD_DIV, MAXP, MINN, 32'h1, 0);
        send_request(CMD_DIV, MINN, MINN, MINN, MINN);
        send_request(CMD_DIV, -ONE, 32'h7, ONE, ONE);
        send_request(CMD_DIV, 32'h1, 0, MAXP, MAXP);
        send_request(CMD_LESS, ONE, 0, 0, ONE);
        send_request(CMD_LESS, MINN, MINN, MAXP, MAXP);
        send_request(CMD_GREATER, MINN, MINN, MAXP, MAXP);
        send_request(CMD_GREATER, 0, 0, 0, 0);
        send_request(CMD_EQUAL, MINN, MAXP, MINN, MAXP);
        send_request(CMD_EQUAL, MINN, MAXP, MINN, MINN);
        send_request(CMD_CONJ, MAXP, MINN, 32'h1234, 32'h5678);
        send_request(CMD_CONJ, MINN, MAXP, 0, 0);

        repeat (500) begin
            c  = t_cmd'($urandom_range(0, 7));
            ar = rand_part();
            ai = rand_part();
            br = rand_part();
            bi = rand_part();
            if ($urandom_range(0, 9) == 0) begin
                br = 0;
                bi = 0;
            end
            if (c == CMD_EQUAL && $urandom_range(0, 1)) begin
                br = ar;
                bi = ai;
            end
            send_request(c, ar, ai, br, bi);
        end
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
